>>> rtl/big_pkg.sv
// Shared constants for the broadcast index generator.
`default_nettype none
package big_pkg;
    localparam int RANK_DEF       = 4;
    localparam int DIM_BITS_DEF   = 12;
    localparam int INDEX_BITS_DEF = 24;

    localparam int FIELD_W = 24;  // width of the index ports
    localparam int CFG_W   = 13;  // widest register
    localparam int SIZE_W  = 13;
    localparam int MASK_W  = 4;
    localparam int ADDR_W  = 3;
    localparam int CFG_DIMS = 4;  // dimensions that have size registers

    // register indexes
    localparam logic [ADDR_W-1:0] REG_DIM_OUTER  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DIM_SECOND = 3'd1;
    localparam logic [ADDR_W-1:0] REG_DIM_THIRD  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DIM_INNER  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_MASK_A     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_MASK_B     = 3'd5;

    // cell kinds
    localparam int CELL_DIV = 0;  // one quotient bit
    localparam int CELL_MUL = 1;  // coordinate times stride, next stride
    localparam int CELL_ACC = 2;  // add products, clear remainder
endpackage
`default_nettype wire

>>> rtl/big_cell.sv
// One cell of the index chain: a division bit step, a multiply step or an add step.
`default_nettype none
module big_cell
    import big_pkg::*;
#(
    parameter int KIND       = CELL_DIV,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic [DIM_BITS:0]     dsize,
    input  wire logic                  mask_a,
    input  wire logic                  mask_b,
    input  wire logic                  in_valid,
    input  wire logic [INDEX_BITS-1:0] in_num,
    input  wire logic [DIM_BITS-1:0]   in_rem,
    input  wire logic [INDEX_BITS-1:0] in_acc_a,
    input  wire logic [INDEX_BITS-1:0] in_acc_b,
    input  wire logic [INDEX_BITS-1:0] in_str_a,
    input  wire logic [INDEX_BITS-1:0] in_str_b,
    input  wire logic [INDEX_BITS-1:0] in_prod_a,
    input  wire logic [INDEX_BITS-1:0] in_prod_b,
    output logic                       out_valid,
    output logic [INDEX_BITS-1:0]      out_num,
    output logic [DIM_BITS-1:0]        out_rem,
    output logic [INDEX_BITS-1:0]      out_acc_a,
    output logic [INDEX_BITS-1:0]      out_acc_b,
    output logic [INDEX_BITS-1:0]      out_str_a,
    output logic [INDEX_BITS-1:0]      out_str_b,
    output logic [INDEX_BITS-1:0]      out_prod_a,
    output logic [INDEX_BITS-1:0]      out_prod_b
);
    localparam int IB = INDEX_BITS;
    localparam int DW = DIM_BITS + 1;

    logic            valid_reg;
    logic [IB-1:0]   num_reg, num_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;
    logic [IB-1:0]   acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [IB-1:0]   str_a_reg, str_a_next, str_b_reg, str_b_next;
    logic [IB-1:0]   prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic [DW-1:0]   r2;
    logic            ge;

    assign r2 = {in_rem, in_num[IB-1]};
    assign ge = (r2 >= dsize);

    always_comb begin
        num_next    = in_num;
        rem_next    = in_rem;
        acc_a_next  = in_acc_a;
        acc_b_next  = in_acc_b;
        str_a_next  = in_str_a;
        str_b_next  = in_str_b;
        prod_a_next = in_prod_a;
        prod_b_next = in_prod_b;
        if (KIND == CELL_DIV) begin
            // restoring division, one quotient bit
            num_next = (in_num << 1) | IB'(ge);
            rem_next = ge ? DIM_BITS'(r2 - dsize) : DIM_BITS'(r2);
        end else if (KIND == CELL_MUL) begin
            prod_a_next = mask_a ? '0 : IB'(IB'(in_rem) * in_str_a);
            prod_b_next = mask_b ? '0 : IB'(IB'(in_rem) * in_str_b);
            str_a_next  = mask_a ? in_str_a : IB'(in_str_a * IB'(dsize));
            str_b_next  = mask_b ? in_str_b : IB'(in_str_b * IB'(dsize));
        end else begin
            acc_a_next = in_acc_a + in_prod_a;
            acc_b_next = in_acc_b + in_prod_b;
            rem_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= num_next;
            rem_reg    <= rem_next;
            acc_a_reg  <= acc_a_next;
            acc_b_reg  <= acc_b_next;
            str_a_reg  <= str_a_next;
            str_b_reg  <= str_b_next;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_num    = num_reg;
    assign out_rem    = rem_reg;
    assign out_acc_a  = acc_a_reg;
    assign out_acc_b  = acc_b_reg;
    assign out_str_a  = str_a_reg;
    assign out_str_b  = str_b_reg;
    assign out_prod_a = prod_a_reg;
    assign out_prod_b = prod_b_reg;
endmodule
`default_nettype wire

>>> rtl/broadcast_index_generator_top.sv
// Top level of the broadcast index generator: config registers and the cell chain.
//
// Usage:
//   Input channel s_valid/s_ready carries out_index, a flat row-major index into
//   the broadcast result. Output channel m_valid/m_ready carries index_a and
//   index_b, the flat indices into the two operands. One result per item.
//   Config: cfg_wr_en/cfg_addr/cfg_wdata write the four dimension sizes
//   (outer first) and the two broadcast masks; write only while idle.
// Structure: each dimension takes INDEX_BITS one-bit division cells, a
//   multiply cell and an add cell.
// Throughput: one item per cycle; the chain moves every cycle m_ready is high
//   or the output register is empty.
// Stall: when the receiver holds m_ready low with a result waiting, the whole
//   chain freezes and s_ready drops; nothing is lost.
// Reset: aresetn (sync, low) empties the chain, sizes go to 1, masks to 0.
`default_nettype none
module broadcast_index_generator_top
    import big_pkg::*;
#(
    parameter int RANK       = RANK_DEF,
    parameter int DIM_BITS   = DIM_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [FIELD_W-1:0] s_out_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FIELD_W-1:0]      m_index_a,
    output logic [FIELD_W-1:0]      m_index_b
);
    localparam int IB  = INDEX_BITS;
    localparam int DW  = DIM_BITS + 1;
    localparam int PER = IB + 2;       // cells per dimension
    localparam int NST = RANK * PER;   // cells in the chain

    // config registers, dimension 0 is innermost
    logic [SIZE_W-1:0] size_reg [0:CFG_DIMS-1];
    logic [MASK_W-1:0] mask_a_reg, mask_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_DIMS; i++) begin
                size_reg[i] <= SIZE_W'(1);
            end
            mask_a_reg <= '0;
            mask_b_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DIM_OUTER:  size_reg[3] <= cfg_wdata[SIZE_W-1:0];
                REG_DIM_SECOND: size_reg[2] <= cfg_wdata[SIZE_W-1:0];
                REG_DIM_THIRD:  size_reg[1] <= cfg_wdata[SIZE_W-1:0];
                REG_DIM_INNER:  size_reg[0] <= cfg_wdata[SIZE_W-1:0];
                REG_MASK_A:     mask_a_reg  <= cfg_wdata[MASK_W-1:0];
                REG_MASK_B:     mask_b_reg  <= cfg_wdata[MASK_W-1:0];
                default: ;  // unknown register, ignored
            endcase
        end
    end

    // effective sizes: zero acts as one, large values saturate at 2^DIM_BITS
    logic [DW-1:0] dsize [0:RANK-1];
    logic          mka   [0:RANK-1];
    logic          mkb   [0:RANK-1];

    for (genvar k = 0; k < RANK; k++) begin : g_dim
        if (k < CFG_DIMS) begin : g_cfg
            logic [25:0] v_ext;
            assign v_ext = 26'(size_reg[k]);
            always_comb begin
                if (size_reg[k] == '0) begin
                    dsize[k] = DW'(1);
                end else if (v_ext > (26'(1) << DIM_BITS)) begin
                    dsize[k] = DW'(1) << DIM_BITS;
                end else begin
                    dsize[k] = DW'(size_reg[k]);
                end
            end
            assign mka[k] = mask_a_reg[k];
            assign mkb[k] = mask_b_reg[k];
        end else begin : g_fixed
            assign dsize[k] = DW'(1);
            assign mka[k]   = 1'b0;
            assign mkb[k]   = 1'b0;
        end
    end

    // chain wiring, element 0 is the input port
    logic                vld_w  [0:NST];
    logic [IB-1:0]       num_w  [0:NST];
    logic [DIM_BITS-1:0] rem_w  [0:NST];
    logic [IB-1:0]       acca_w [0:NST];
    logic [IB-1:0]       accb_w [0:NST];
    logic [IB-1:0]       stra_w [0:NST];
    logic [IB-1:0]       strb_w [0:NST];
    logic [IB-1:0]       prda_w [0:NST];
    logic [IB-1:0]       prdb_w [0:NST];
    logic                en;

    // whole chain advances together; the last cell is the output register
    assign en      = !vld_w[NST] || m_ready;
    assign s_ready = en;

    assign vld_w[0]  = s_valid;
    assign num_w[0]  = IB'(s_out_index);
    assign rem_w[0]  = '0;
    assign acca_w[0] = '0;
    assign accb_w[0] = '0;
    assign stra_w[0] = IB'(1);
    assign strb_w[0] = IB'(1);
    assign prda_w[0] = '0;
    assign prdb_w[0] = '0;

    for (genvar s = 0; s < NST; s++) begin : g_cell
        localparam int DIMK = s / PER;
        localparam int POS  = s % PER;
        localparam int KND  = (POS < IB) ? CELL_DIV :
                              (POS == IB) ? CELL_MUL : CELL_ACC;
        big_cell #(
            .KIND       (KND),
            .DIM_BITS   (DIM_BITS),
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .dsize      (dsize[DIMK]),
            .mask_a     (mka[DIMK]),
            .mask_b     (mkb[DIMK]),
            .in_valid   (vld_w[s]),
            .in_num     (num_w[s]),
            .in_rem     (rem_w[s]),
            .in_acc_a   (acca_w[s]),
            .in_acc_b   (accb_w[s]),
            .in_str_a   (stra_w[s]),
            .in_str_b   (strb_w[s]),
            .in_prod_a  (prda_w[s]),
            .in_prod_b  (prdb_w[s]),
            .out_valid  (vld_w[s+1]),
            .out_num    (num_w[s+1]),
            .out_rem    (rem_w[s+1]),
            .out_acc_a  (acca_w[s+1]),
            .out_acc_b  (accb_w[s+1]),
            .out_str_a  (stra_w[s+1]),
            .out_str_b  (strb_w[s+1]),
            .out_prod_a (prda_w[s+1]),
            .out_prod_b (prdb_w[s+1])
        );
    end

    assign m_valid   = vld_w[NST];
    assign m_index_a = FIELD_W'(acca_w[NST]);
    assign m_index_b = FIELD_W'(accb_w[NST]);
endmodule
`default_nettype wire

>>> rtl/big_checker.sv
// Port-level checks for the broadcast index generator, bound to the top level.
`default_nettype none
module big_checker
    import big_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [FIELD_W-1:0] m_index_a,
    input wire logic [FIELD_W-1:0] m_index_b
);
    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_index_a) && $stable(m_index_b))
        else $error("result changed while stalled");

    // chain is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result present after reset");

    // input only backs up when the receiver stalls a waiting result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // a stall with input waiting keeps input blocked while the stall lasts
    a_stall_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");
endmodule

bind broadcast_index_generator_top big_checker u_big_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_index_a (m_index_a),
    .m_index_b (m_index_b)
);
`default_nettype wire
